FILE: rtl/avs_pkg.sv
// shared types and constants for the ascending value sorter
// used by avs_cell and ascending_value_sorter_core, no dependencies
package avs_pkg;

  localparam int unsigned DataW = 32;

  // what one cell shows its neighbors
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] value;
    logic             gt;     // held value ranks above the incoming one
  } avs_link_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } avs_state_e;

endpackage

FILE: rtl/avs_cell.sv
// one cell of the insertion chain: holds one value, shifts right on insert
// and left on pop; depends on avs_pkg
module avs_cell
  import avs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             insert_i,
  input  logic             pop_i,
  input  logic [DataW-1:0] x_i,
  input  avs_link_t        left_i,
  input  avs_link_t        right_i,
  output avs_link_t        link_o
);

  logic             valid_q, valid_d;
  logic [DataW-1:0] value_q, value_d;
  logic             gt;

  // an empty cell ranks above everything
  assign gt = !valid_q || ($signed(value_q) > $signed(x_i));

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (insert_i && gt) begin
      valid_d = left_i.gt ? left_i.valid : 1'b1;
      value_d = left_i.gt ? left_i.value : x_i;
    end else if (pop_i) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.value = value_q;
  assign link_o.gt    = gt;

endmodule

FILE: rtl/ascending_value_sorter_core.sv
// Sorts a batch of signed 32-bit values, lowest first. Each accepted value is
// inserted into a row of MAX_ITEMS cells, so a batch loads at one item per
// cycle. The batch closes on tlast or when the row is full; the row then
// shifts out one result per cycle toward the output while m_axis_tready is
// high, tlast on the largest, and no input is taken until the final result
// is delivered. Depends on avs_pkg and avs_cell.
module ascending_value_sorter_core
  import avs_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,   // [31:0] value
  input  logic             s_axis_tlast,   // last_item
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,   // [31:0] sorted_value
  output logic             m_axis_tlast    // last_result
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  avs_state_e      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            in_req, out_req, closes;
  avs_link_t       link [MAX_ITEMS];
  avs_link_t       edge_l, edge_r;

  assign s_axis_tready = (state_q == ST_FILL);
  assign m_axis_tvalid = (state_q == ST_DRAIN);
  assign in_req  = s_axis_tvalid && s_axis_tready;
  assign out_req = m_axis_tvalid && m_axis_tready;
  assign closes  = s_axis_tlast || (count_q == CntW'(MAX_ITEMS - 1));

  // the head cell always takes the new value when an insert moves it
  assign edge_l = '{valid: 1'b0, value: '0, gt: 1'b0};
  assign edge_r = '{valid: 1'b0, value: '0, gt: 1'b0};

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    avs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .insert_i(in_req),
      .pop_i   (out_req),
      .x_i     (s_axis_tdata),
      .left_i  ((i == 0) ? edge_l : link[(i == 0) ? 0 : i - 1]),
      .right_i ((i == MAX_ITEMS - 1) ? edge_r : link[(i == MAX_ITEMS - 1) ? i : i + 1]),
      .link_o  (link[i])
    );
  end

  assign m_axis_tdata = link[0].value;
  assign m_axis_tlast = (count_q == CntW'(1));

  // count_q holds the items loaded while filling and the items left while draining
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    case (state_q)
      ST_FILL: begin
        if (in_req) begin
          count_d = count_q + CntW'(1);
          if (closes) state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_req) begin
          count_d = count_q - CntW'(1);
          if (count_q == CntW'(1)) state_d = ST_FILL;
        end
      end
      default: begin
        state_d = ST_FILL;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> link[0].valid)
    else $error("result offered from an empty head cell");

  a_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($countones({link[1].valid, link[0].valid}) == 2) || m_axis_tlast)
    else $error("last flag out of step with cell contents");

  a_close_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req && closes) |=> m_axis_tvalid && !s_axis_tready)
    else $error("closed batch did not start unloading");

  a_empty_after : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_req && m_axis_tlast) |=> !link[0].valid && s_axis_tready)
    else $error("cells not empty after final result");

endmodule
